// ===== rtl/cpls_pkg.sv =====
`timescale 1ns / 1ps
package cpls_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int STACK_DEPTH = 64;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SEW  = 2 * CNTW;
  localparam int KIW  = 6;

  // Arithmetic widths: differences, sums of products, multiplier operands.
  localparam int DW   = COORD_BITS + 1;
  localparam int SW   = 2 * DW + 1;
  localparam int HW   = (SW + 1) / 2;
  localparam int TOLW = 16;
  localparam int TSQW = 2 * TOLW;
  localparam int MAW  = SW + 1;
  localparam int MBW0 = (HW + 1 > TOLW + 1) ? HW + 1 : TOLW + 1;
  localparam int MBW  = (MBW0 > DW) ? MBW0 : DW;
  localparam int PW   = MAW + MBW;
  localparam int AWW  = 2 * SW;
  localparam int ARW  = SW + TSQW;
  localparam int CMPW = 2 * SW + 8;

  localparam int PAW = 3;
  localparam logic [0:0] REG_TOLERANCE = 1'b0;
  localparam logic [TOLW-1:0] TOL_RESET = 16'd16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         loop_end;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kept_x;
    logic signed [COORD_BITS-1:0] kept_y;
    logic [KIW-1:0]               kept_index;
    logic                         last_kept;
    logic                         overflowed;
  } kept_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_P0, S_FRD, S_FX, S_FY, S_FCMP, S_FDONE,
    S_PUSHA, S_PUSHB, S_POP, S_SPAN, S_SP, S_SQ, S_LY, S_LSUM,
    S_RD, S_RX, S_RY, S_RCMP, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
    S_ESCAN, S_EOUT
  } state_e;

endpackage

// ===== rtl/cpls_ram.sv =====
`timescale 1ns / 1ps
module cpls_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/closed_loop_polyline_simplifier_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// point     start_i, point_i, busy_o                beat when start_i high and busy_o low
// kept      kept_valid_o, kept_o                    one beat per cycle with kept_valid_o
// config    psel, penable, pwrite, paddr, pwdata    APB write, pready always high
//
// A point that does not close the loop is stored; the closing point starts a run.
// With one shared multiplier and one vertex read port, a run reads vertex 0 and searches
// for the vertex farthest from it, then per span reads both ends, measures each interior
// point, tests the worst against the tolerance and pushes new spans, then scans every
// vertex and sends each kept one.
// Reset is asynchronous and active low; it clears control state and sets the tolerance to 16.
// The receiver cannot stall; busy_o stays high until the last kept beat is out.
module closed_loop_polyline_simplifier_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  cpls_pkg::point_t             point_i,
  output logic                         busy_o,
  output logic                         kept_valid_o,
  output cpls_pkg::kept_t              kept_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpls_pkg::PAW-1:0]     paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cpls_pkg::*;

  localparam int CW = COORD_BITS;

  state_e state_q, state_d;

  logic [CNTW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [TOLW-1:0]       tol_q;
  logic [MAX_POINTS-1:0] marks_q, marks_d;
  logic [SPW-1:0]        sp_q, sp_d;
  logic [CNTW-1:0]       i_q, i_d;
  logic [CNTW-1:0]       a_q, a_d, b_q, b_d;
  logic [IW-1:0]         qi_q, qi_d, at_q, at_d;
  logic                  have_q, have_d;
  logic [SW-1:0]         worst_q, worst_d;
  logic signed [CW-1:0]  px_q, px_d, py_q, py_d, rx_q, rx_d, ry_q, ry_d;
  logic signed [DW-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [SW-1:0]  acc_q, acc_d;
  logic [SW-1:0]         lsq_q, lsq_d;
  logic [TSQW-1:0]       tsq_q, tsq_d;
  logic [AWW-1:0]        accw_q, accw_d;
  logic [ARW-1:0]        accr_q, accr_d;
  logic [SEW-1:0]        span1_q, span1_d, span2_q, span2_d;

  // Shared multiplier with a registered product.
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_q;

  // Vertex store and span stack ports.
  logic                  v_we;
  logic [IW-1:0]         v_waddr, v_raddr;
  logic [2*CW-1:0]       v_wdata, v_rdata;
  logic                  s_we;
  logic [SAW-1:0]        s_waddr, s_raddr;
  logic [SEW-1:0]        s_wdata, s_rdata;

  logic                  accept;
  logic signed [CW-1:0]  vx, vy;
  logic signed [DW-1:0]  ex, ey, ry_d_diff;
  logic signed [SW-1:0]  prod_s;
  logic signed [SW:0]    diff;
  logic [SW-1:0]         meas, sum_sq;
  logic [CNTW-1:0]       e_a, e_b;
  logic [SPW-1:0]        sp_m1;
  logic                  beyond, lsq_zero, skip_span, last_kept;
  logic [CMPW-1:0]       cmp_l, cmp_r;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != S_IDLE);
  assign vx       = $signed(v_rdata[2*CW-1:CW]);
  assign vy       = $signed(v_rdata[CW-1:0]);
  assign ex       = DW'(vx) - DW'(px_q);
  assign ey       = DW'(ry_q) - DW'(py_q);
  assign ry_d_diff = DW'(py_q) - DW'(vy);
  assign prod_s   = SW'(prod_q);
  assign sum_sq   = SW'(acc_q + prod_s);
  assign diff     = (SW + 1)'(acc_q) - (SW + 1)'(prod_s);
  assign e_a      = s_rdata[SEW-1:CNTW];
  assign e_b      = s_rdata[CNTW-1:0];
  assign sp_m1    = sp_q - 1'b1;
  assign lsq_zero = (lsq_q == '0);
  assign skip_span = (e_b > count_q) ||
                     ({1'b0, e_b} <= ({1'b0, e_a} + 1'b1));
  assign cmp_l    = {accw_q, 8'b0};
  assign cmp_r    = CMPW'(accr_q);
  assign last_kept = ((marks_q & ({MAX_POINTS{1'b1}} << (i_q + 1'b1))) == '0);

  // Cross product size is the difference of two products; coincident ends use sum_sq.
  always_comb begin
    if (lsq_zero) begin
      meas = sum_sq;
    end else if (diff[SW]) begin
      meas = SW'(-diff);
    end else begin
      meas = SW'(diff);
    end
  end

  // Beyond the tolerance: with coincident end points the test needs no product.
  always_comb begin
    if (state_q == S_T0) begin
      beyond = ({worst_q, 8'b0} > (SW + 8)'(tsq_q));
    end else begin
      beyond = (cmp_l > cmp_r);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && point_i.loop_end) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = (count_q < CNTW'(4)) ? S_ESCAN : S_P0;
      end
      S_P0:    state_d = S_FRD;
      S_FRD:   state_d = S_FX;
      S_FX:    state_d = S_FY;
      S_FY:    state_d = S_FCMP;
      S_FCMP: begin
        state_d = ((i_q + 1'b1) < count_q) ? S_FRD : S_FDONE;
      end
      S_FDONE: state_d = S_PUSHA;
      S_PUSHA: state_d = S_PUSHB;
      S_PUSHB: state_d = S_POP;
      S_POP: begin
        state_d = (sp_q == '0) ? S_ESCAN : S_SPAN;
      end
      S_SPAN: begin
        state_d = skip_span ? S_POP : S_SP;
      end
      S_SP:    state_d = S_SQ;
      S_SQ:    state_d = S_LY;
      S_LY:    state_d = S_LSUM;
      S_LSUM:  state_d = S_RD;
      S_RD:    state_d = S_RX;
      S_RX:    state_d = S_RY;
      S_RY:    state_d = S_RCMP;
      S_RCMP: begin
        state_d = ((i_q + 1'b1) < b_q) ? S_RD : S_T0;
      end
      S_T0: begin
        if (!lsq_zero) begin
          state_d = S_T1;
        end else begin
          state_d = beyond ? S_PUSHA : S_POP;
        end
      end
      S_T1:    state_d = S_T2;
      S_T2:    state_d = S_T3;
      S_T3:    state_d = S_T4;
      S_T4:    state_d = S_T5;
      S_T5: begin
        state_d = beyond ? S_PUSHA : S_POP;
      end
      S_ESCAN: begin
        if (i_q >= count_q) begin
          state_d = S_IDLE;
        end else if (marks_q[i_q[IW-1:0]]) begin
          state_d = S_EOUT;
        end
      end
      S_EOUT:  state_d = S_ESCAN;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    count_d = count_q;  ovf_d   = ovf_q;   marks_d = marks_q; sp_d    = sp_q;
    i_d     = i_q;      a_d     = a_q;     b_d     = b_q;     qi_d    = qi_q;
    at_d    = at_q;     have_d  = have_q;  worst_d = worst_q;
    px_d    = px_q;     py_d    = py_q;    rx_d    = rx_q;    ry_d    = ry_q;
    dx_d    = dx_q;     dy_d    = dy_q;    acc_d   = acc_q;   lsq_d   = lsq_q;
    tsq_d   = tsq_q;    accw_d  = accw_q;  accr_d  = accr_q;
    span1_d = span1_q;  span2_d = span2_q;
    mul_a   = '0;       mul_b   = '0;
    v_we    = 1'b0;
    v_waddr = count_q[IW-1:0];
    v_wdata = {point_i.point_x, point_i.point_y};
    v_raddr = i_q[IW-1:0];
    s_we    = 1'b0;
    s_waddr = sp_q[SAW-1:0];
    s_wdata = span1_q;
    s_raddr = sp_m1[SAW-1:0];
    kept_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (count_q < CNTW'(MAX_POINTS)) begin
            v_we    = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_SETUP: begin
        mul_a   = MAW'($signed({1'b0, tol_q}));
        mul_b   = MBW'($signed({1'b0, tol_q}));
        v_raddr = '0;
        i_d     = '0;
        if (count_q < CNTW'(4)) begin
          for (int k = 0; k < MAX_POINTS; k++) begin
            marks_d[k] = (CNTW'(k) < count_q);
          end
        end
      end
      S_P0: begin
        tsq_d  = TSQW'(prod_q);
        px_d   = vx;
        py_d   = vy;
        i_d    = CNTW'(1);
        have_d = 1'b0;
      end
      S_FX: begin
        ry_d  = vy;
        mul_a = MAW'(ex);
        mul_b = MBW'(ex);
      end
      S_FY: begin
        acc_d = prod_s;
        mul_a = MAW'(ey);
        mul_b = MBW'(ey);
      end
      S_FCMP: begin
        if (!have_q || (sum_sq > worst_q)) begin
          worst_d = sum_sq;
          at_d    = i_q[IW-1:0];
          have_d  = 1'b1;
        end
        i_d = i_q + 1'b1;
      end
      S_FDONE: begin
        marks_d[0]    = 1'b1;
        marks_d[at_q] = 1'b1;
        sp_d          = '0;
        span1_d       = {CNTW'(at_q), count_q};
        span2_d       = {CNTW'(0), CNTW'(at_q)};
      end
      S_PUSHA: begin
        s_wdata = span1_q;
        if ((span1_q[CNTW-1:0] > span1_q[SEW-1:CNTW] + 1'b1) &&
            (sp_q < SPW'(STACK_DEPTH))) begin
          s_we = 1'b1;
          sp_d = sp_q + 1'b1;
        end
      end
      S_PUSHB: begin
        s_wdata = span2_q;
        if ((span2_q[CNTW-1:0] > span2_q[SEW-1:CNTW] + 1'b1) &&
            (sp_q < SPW'(STACK_DEPTH))) begin
          s_we = 1'b1;
          sp_d = sp_q + 1'b1;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          i_d = '0;
        end else begin
          sp_d = sp_m1;
        end
      end
      S_SPAN: begin
        a_d     = e_a;
        b_d     = e_b;
        qi_d    = (e_b >= count_q) ? '0 : e_b[IW-1:0];
        v_raddr = e_a[IW-1:0];
      end
      S_SP: begin
        px_d    = vx;
        py_d    = vy;
        v_raddr = qi_q;
      end
      S_SQ: begin
        dx_d  = DW'(vx) - DW'(px_q);
        dy_d  = DW'(vy) - DW'(py_q);
        mul_a = MAW'(DW'(vx) - DW'(px_q));
        mul_b = MBW'(DW'(vx) - DW'(px_q));
      end
      S_LY: begin
        acc_d = prod_s;
        mul_a = MAW'(dy_q);
        mul_b = MBW'(dy_q);
      end
      S_LSUM: begin
        lsq_d  = sum_sq;
        i_d    = a_q + 1'b1;
        have_d = 1'b0;
      end
      S_RX: begin
        rx_d = vx;
        ry_d = vy;
        if (!lsq_zero) begin
          mul_a = MAW'(dx_q);
          mul_b = MBW'(ry_d_diff);
        end else begin
          mul_a = MAW'(ex);
          mul_b = MBW'(ex);
        end
      end
      S_RY: begin
        acc_d = prod_s;
        if (!lsq_zero) begin
          mul_a = MAW'(DW'(px_q) - DW'(rx_q));
          mul_b = MBW'(dy_q);
        end else begin
          mul_a = MAW'(ey);
          mul_b = MBW'(ey);
        end
      end
      S_RCMP: begin
        if (!have_q || (meas > worst_q)) begin
          worst_d = meas;
          at_d    = i_q[IW-1:0];
          have_d  = 1'b1;
        end
        i_d = i_q + 1'b1;
      end
      S_T0: begin
        mul_a = MAW'($signed({1'b0, worst_q}));
        mul_b = MBW'($signed({1'b0, worst_q[HW-1:0]}));
        if (lsq_zero && beyond) begin
          marks_d[at_q] = 1'b1;
          span1_d       = {CNTW'(at_q), b_q};
          span2_d       = {a_q, CNTW'(at_q)};
        end
      end
      S_T1: begin
        accw_d = AWW'(prod_q);
        mul_a  = MAW'($signed({1'b0, worst_q}));
        mul_b  = MBW'($signed({1'b0, worst_q[SW-1:HW]}));
      end
      S_T2: begin
        accw_d = accw_q + (AWW'(prod_q) << HW);
        mul_a  = MAW'($signed({1'b0, lsq_q}));
        mul_b  = MBW'($signed({1'b0, tsq_q[TOLW-1:0]}));
      end
      S_T3: begin
        accr_d = ARW'(prod_q);
        mul_a  = MAW'($signed({1'b0, lsq_q}));
        mul_b  = MBW'($signed({1'b0, tsq_q[TSQW-1:TOLW]}));
      end
      S_T4: begin
        accr_d = accr_q + (ARW'(prod_q) << TOLW);
      end
      S_T5: begin
        if (beyond) begin
          marks_d[at_q] = 1'b1;
          span1_d       = {CNTW'(at_q), b_q};
          span2_d       = {a_q, CNTW'(at_q)};
        end
      end
      S_ESCAN: begin
        if (i_q >= count_q) begin
          marks_d = '0;
          count_d = '0;
          ovf_d   = 1'b0;
          sp_d    = '0;
        end else if (!marks_q[i_q[IW-1:0]]) begin
          i_d = i_q + 1'b1;
        end
      end
      S_EOUT: begin
        kept_valid_o = 1'b1;
        i_d          = i_q + 1'b1;
      end
      default: ;
    endcase
  end

  // The kept beat reads the vertex fetched during the scan cycle before it.
  always_comb begin
    kept_o.kept_x     = vx;
    kept_o.kept_y     = vy;
    kept_o.kept_index = KIW'(i_q[IW-1:0]);
    kept_o.last_kept  = last_kept;
    kept_o.overflowed = ovf_q;
  end

  // Configuration port: one register, the tolerance.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? 32'(tol_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE)) begin
      tol_q <= pwdata[TOLW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      marks_q <= '0;
      sp_q    <= '0;
      i_q     <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      marks_q <= marks_d;
      sp_q    <= sp_d;
      i_q     <= i_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;     b_q     <= b_d;     qi_q    <= qi_d;    at_q    <= at_d;
    worst_q <= worst_d; px_q    <= px_d;    py_q    <= py_d;    rx_q    <= rx_d;
    ry_q    <= ry_d;    dx_q    <= dx_d;    dy_q    <= dy_d;    acc_q   <= acc_d;
    lsq_q   <= lsq_d;   tsq_q   <= tsq_d;   accw_q  <= accw_d;  accr_q  <= accr_d;
    span1_q <= span1_d; span2_q <= span2_d;
    prod_q  <= mul_a * mul_b;
  end

  cpls_ram #(.Width(2 * CW), .Depth(MAX_POINTS)) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  cpls_ram #(.Width(SEW), .Depth(STACK_DEPTH)) u_span_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

`ifndef NO_ASSERTIONS
  a_kept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_o |-> busy_o) else $error("kept beat outside a simplification run");

  a_close_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && point_i.loop_end) |=> busy_o) else $error("closing point did not start a run");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH)) else $error("span stack pointer beyond depth");

  a_last_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_valid_o && kept_o.last_kept) |=> !kept_valid_o)
    else $error("kept beat after the last one");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (marks_q == '0)) else $error("keep marks left over");
`endif

endmodule

// ===== tb/tb_closed_loop_polyline_simplifier_core.sv =====
`timescale 1ns / 1ps
module tb_closed_loop_polyline_simplifier_core;
  import cpls_pkg::*;

  localparam int LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  point_t      point_i = '0;
  logic        busy_o;
  logic        kept_valid_o;
  kept_t       kept_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  closed_loop_polyline_simplifier_core dut (.*);

  always #10 clk_i = ~clk_i;

  // Stimulus waiting to be driven, and the kept vertices we expect back.
  point_t pending_points[$];
  kept_t  expected_kept[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     gap_pct = 0;
  logic   sender_done = 1'b0;

  // Our own copy of the block's state, updated as each point beat is accepted.
  logic signed [63:0] loop_x[MAX_POINTS];
  logic signed [63:0] loop_y[MAX_POINTS];
  bit   keep_flag[MAX_POINTS];
  int   loop_len = 0;
  bit   loop_overflowed = 0;
  logic [15:0] tol_q4 = TOL_RESET;

  // Exact test of whether the worst deviation of a span exceeds the tolerance.
  function automatic bit beyond_tolerance(logic [127:0] worst, logic [127:0] len_sq);
    logic [127:0] tsq;
    tsq = tol_q4 * tol_q4;
    if (len_sq != 0) return (worst * worst * 256) > (tsq * len_sq);
    return (worst * 256) > tsq;
  endfunction

  // Douglas-Peucker over the loaded loop, spans kept on an explicit stack.
  task automatic simplify_loop();
    int span_a[$];
    int span_b[$];
    int far_i, a, b, qi, at;
    logic [127:0] best, d, worst, m, len_sq;
    logic signed [63:0] dx, dy, ex, ey;
    bit have;
    for (int i = 0; i < MAX_POINTS; i++) keep_flag[i] = 0;
    if (loop_len < 4) begin
      for (int i = 0; i < loop_len; i++) keep_flag[i] = 1;
      return;
    end
    far_i = 0;
    best = 0;
    have = 0;
    for (int i = 1; i < loop_len; i++) begin
      dx = loop_x[i] - loop_x[0];
      dy = loop_y[i] - loop_y[0];
      d = dx * dx + dy * dy;
      if (!have || d > best) begin
        best = d;
        far_i = i;
        have = 1;
      end
    end
    keep_flag[0] = 1;
    keep_flag[far_i] = 1;
    if (loop_len > far_i + 1) begin
      span_a = {span_a, far_i};
      span_b = {span_b, loop_len};
    end
    if (far_i > 1) begin
      span_a = {span_a, 0};
      span_b = {span_b, far_i};
    end
    while (span_a.size() > 0) begin
      a = span_a.pop_back();
      b = span_b.pop_back();
      qi = (b >= loop_len) ? 0 : b;
      dx = loop_x[qi] - loop_x[a];
      dy = loop_y[qi] - loop_y[a];
      len_sq = dx * dx + dy * dy;
      worst = 0;
      at = 0;
      have = 0;
      for (int i = a + 1; i < b; i++) begin
        if (len_sq != 0) begin
          ex = dx * (loop_y[a] - loop_y[i]) - (loop_x[a] - loop_x[i]) * dy;
          m = (ex < 0) ? -ex : ex;
        end else begin
          ex = loop_x[i] - loop_x[a];
          ey = loop_y[i] - loop_y[a];
          m = ex * ex + ey * ey;
        end
        if (!have || m > worst) begin
          worst = m;
          at = i;
          have = 1;
        end
      end
      if (beyond_tolerance(worst, len_sq)) begin
        keep_flag[at] = 1;
        if (b > at + 1) begin
          span_a = {span_a, at};
          span_b = {span_b, b};
        end
        if (at > a + 1) begin
          span_a = {span_a, a};
          span_b = {span_b, at};
        end
      end
    end
  endtask

  // Store an accepted point; on the closing point, queue the kept vertices.
  task automatic accept_point(point_t p);
    int total, k;
    kept_t e;
    if (loop_len < MAX_POINTS) begin
      loop_x[loop_len] = p.point_x;
      loop_y[loop_len] = p.point_y;
      loop_len++;
    end else begin
      loop_overflowed = 1;
    end
    if (!p.loop_end) return;
    simplify_loop();
    total = 0;
    for (int i = 0; i < loop_len; i++) total += keep_flag[i];
    k = 0;
    for (int i = 0; i < loop_len; i++) begin
      if (keep_flag[i]) begin
        e.kept_x = loop_x[i][15:0];
        e.kept_y = loop_y[i][15:0];
        e.kept_index = i[5:0];
        e.last_kept = (k + 1 == total);
        e.overflowed = loop_overflowed;
        expected_kept = {expected_kept, e};
        k++;
      end
    end
    loop_len = 0;
    loop_overflowed = 0;
  endtask

  // Driver: offers the next pending point unless the current gap draw says idle.
  always @(posedge clk_i) begin
    logic taken;
    cycles <= cycles + 1;
    taken = start_i && !busy_o;
    if (rst_ni) begin
      if (taken) begin
        accept_point(point_i);
        void'(pending_points.pop_front());
      end
      if (pending_points.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start_i <= 1'b1;
        point_i <= pending_points[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every kept beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    kept_t e;
    if (rst_ni && kept_valid_o) begin
      if (expected_kept.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected kept beat: %p", kept_o);
      end else begin
        e = expected_kept.pop_front();
        if (kept_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Kept beat differs: expected %p, actual %p", e, kept_o);
        end
      end
    end
  end

  // A watchdog that should never fire on a correct block.
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_tolerance(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_TOLERANCE, 2'b00};
    pwdata <= {16'($urandom_range(65535)), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_q4 = v;
  endtask

  function automatic point_t make_point(int x, int y, bit last);
    point_t p;
    p.point_x = x[15:0];
    p.point_y = y[15:0];
    p.loop_end = last;
    return p;
  endfunction

  // Put one point at the back of the pending queue.
  task automatic queue_point(point_t p);
    pending_points = {pending_points, p};
  endtask

  // Wait until every point is taken and every kept vertex is back, then let
  // the block settle for a while.
  task automatic drain();
    while (pending_points.size() > 0 || start_i || busy_o || expected_kept.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // A loop of random content: mostly a noisy circle, sometimes raw noise.
  task automatic queue_random_loop(int len);
    int cx, cy, r, mode;
    real ang;
    mode = $urandom_range(9);
    cx = $urandom_range(20000) - 10000;
    cy = $urandom_range(20000) - 10000;
    r = $urandom_range(2000) + 1;
    for (int i = 0; i < len; i++) begin
      if (mode < 7) begin
        ang = 6.2831853 * i / len;
        queue_point(make_point(cx + $rtoi(r * $cos(ang)) + $urandom_range(6) - 3,
                               cy + $rtoi(r * $sin(ang)) + $urandom_range(6) - 3,
                               i == len - 1));
      end else begin
        queue_point(make_point($urandom_range(65535), $urandom_range(65535),
                               i == len - 1));
      end
    end
  endtask

  initial begin
    int sent;
    int len;
    gap_pct = 9;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a single point, a three-point loop, extremes, a square with a
    // spike, a collapsed span where both ends coincide, and a zero tolerance.
    queue_point(make_point(-32768, 32767, 1));
    queue_point(make_point(32767, -32768, 0));
    queue_point(make_point(-32768, -32768, 0));
    queue_point(make_point(32767, 32767, 1));
    queue_point(make_point(0, 0, 0));
    queue_point(make_point(5, 1, 0));
    queue_point(make_point(10, 0, 0));
    queue_point(make_point(10, 10, 0));
    queue_point(make_point(0, 10, 1));
    queue_point(make_point(0, 0, 0));
    queue_point(make_point(3, 3, 0));
    queue_point(make_point(-32768, 32767, 0));
    queue_point(make_point(2, -2, 0));
    queue_point(make_point(0, 0, 0));
    queue_point(make_point(1, 0, 1));
    drain();

    write_tolerance(16'd0);
    queue_random_loop(8);
    drain();
    write_tolerance(16'hFFFF);
    queue_random_loop(10);
    drain();

    // Overflow: 66 points, the closing one dropped along with the extra one.
    write_tolerance(16'd16);
    queue_random_loop(66);
    drain();

    // Random loops in three idling phases with varied tolerances.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 9 : (phase == 1) ? 86 : 0;
      write_tolerance(16'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(64)));
      while (sent < 10 * (phase + 1)) begin
        len = $urandom_range(12, 1);
        queue_random_loop(len);
        sent += len;
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpls_pkg.sv
rtl/cpls_ram.sv
rtl/closed_loop_polyline_simplifier_core.sv
tb/tb_closed_loop_polyline_simplifier_core.sv
